// ===== rtl/afc_pkg.sv =====
// Shared constants and types for the axis-aligned box frustum culling block.
package afc_pkg;

    // Default sizes handed to the top level.
    localparam int DEFAULT_PLANE_COUNT = 6;
    localparam int DEFAULT_COORD_WIDTH = 16;

    // Number of plane registers in the configuration map.
    localparam int REG_COUNT = 6;

    // Configuration port sizes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Packing of one plane register.
    localparam int NORMAL_W    = 16;
    localparam int OFFSET_W    = 16;
    localparam int NORMAL_FRAC = 14;
    localparam int NX_LSB      = 0;
    localparam int NY_LSB      = 16;
    localparam int NZ_LSB      = 32;
    localparam int D_LSB       = 48;

    // Number of axes of a box.
    localparam int AXES = 3;

    // Result beat width: visible in bit 0, padded to one byte.
    localparam int OUT_TDATA_W = 8;

    // Load enables for the plane evaluation stages.
    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic cmp_en;
    } afc_stage_en_t;

endpackage

// ===== rtl/afc_plane_eval.sv =====
// Pipelined plane test: corner select and products, partial sums, final sum and sign.
module afc_plane_eval #(
    parameter int COORD_WIDTH = afc_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic                          aclk,
    input  afc_pkg::afc_stage_en_t        stage_en,
    input  logic [afc_pkg::CFG_DATA_W-1:0] plane,
    input  logic signed [COORD_WIDTH:0]   lo_corner [afc_pkg::AXES],
    input  logic signed [COORD_WIDTH:0]   hi_corner [afc_pkg::AXES],
    output logic                          reject_reg
);
    import afc_pkg::*;

    localparam int CORNER_W = COORD_WIDTH + 1;
    localparam int PROD_W   = CORNER_W + NORMAL_W;
    localparam int D_SCALED_W = OFFSET_W + NORMAL_FRAC;
    localparam int SUM_W    = ((PROD_W > D_SCALED_W) ? PROD_W : D_SCALED_W) + 2;

    logic signed [NORMAL_W-1:0] normal [AXES];
    logic signed [OFFSET_W-1:0] offset;
    logic signed [CORNER_W-1:0] corner [AXES];
    logic signed [PROD_W-1:0]   prod_reg [AXES];
    logic signed [SUM_W-1:0]    sum_a_reg;
    logic signed [SUM_W-1:0]    sum_b_reg;
    logic signed [SUM_W-1:0]    total;

    // Unpack the plane register.
    assign normal[0] = plane[NX_LSB +: NORMAL_W];
    assign normal[1] = plane[NY_LSB +: NORMAL_W];
    assign normal[2] = plane[NZ_LSB +: NORMAL_W];
    assign offset    = plane[D_LSB +: OFFSET_W];

    // Pick the corner deepest inside the plane on each axis and multiply.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            corner[a] = normal[a][NORMAL_W-1] ? hi_corner[a] : lo_corner[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.mul_en) begin
            for (int a = 0; a < AXES; a++) begin
                prod_reg[a] <= normal[a] * corner[a];
            end
        end
    end

    // Two partial sums; the offset is scaled to the product format.
    always_ff @(posedge aclk) begin
        if (stage_en.add_en) begin
            sum_a_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
            sum_b_reg <= SUM_W'(prod_reg[2]) + (SUM_W'(offset) <<< NORMAL_FRAC);
        end
    end

    // The plane rejects the box when the full sum is strictly positive.
    assign total = sum_a_reg + sum_b_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.cmp_en) begin
            reject_reg <= !total[SUM_W-1] && (|total);
        end
    end

endmodule

// ===== rtl/aabb_frustum_cull.sv =====
// Top level of the axis-aligned box frustum culling block.
//
//  channel | direction | beat contents (lowest bit up)
//  --------+-----------+--------------------------------------------------------------
//  s_      | in        | center_x, center_y, center_z, extent_x, extent_y, extent_z
//  m_      | out       | visible
//  cfg_    | in        | plane register write: index, 64-bit packed plane
//
// One box per cycle is accepted while no stall on m_ holds the pipeline.
// The five stages are: corners, corner select and products, partial sums,
// final sum and sign per plane, and the AND of all plane flags into the output.
// Reset clears all plane registers to zero and empties the pipeline.
// A stall on m_ holds each stage that is full; empty stages keep filling.
module aabb_frustum_cull #(
    parameter int PLANE_COUNT = afc_pkg::DEFAULT_PLANE_COUNT,
    parameter int COORD_WIDTH = afc_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input beats.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: center_x, center_y, center_z, extent_x, extent_y, extent_z, zero pad
    input  logic [((6*COORD_WIDTH-3+7)/8)*8-1:0] s_tdata,
    // Result beats.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: visible, zero pad
    output logic [afc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [afc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import afc_pkg::*;

    localparam int CORNER_W = COORD_WIDTH + 1;
    localparam int EXT_W    = COORD_WIDTH - 1;
    localparam int EXT_LSB  = AXES * COORD_WIDTH;

    logic [CFG_DATA_W-1:0]      plane_reg [PLANE_COUNT];
    logic signed [CORNER_W-1:0] lo_reg [AXES];
    logic signed [CORNER_W-1:0] hi_reg [AXES];
    logic [PLANE_COUNT-1:0]     reject;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic m_tvalid_reg;
    logic visible_reg;
    afc_stage_en_t stage_en;

    // Plane registers; writes beyond the list or the plane count are dropped.
    always_ff @(posedge aclk) begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!aresetn) begin
                plane_reg[p] <= '0;
            end else if (cfg_wr_en && (p < REG_COUNT) &&
                         (cfg_index == CFG_INDEX_W'(p))) begin
                plane_reg[p] <= cfg_data;
            end
        end
    end

    // Ready chain: a stage may load when it is empty or its content moves on.
    assign rdy5 = !m_tvalid_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign stage_en.mul_en = rdy2;
    assign stage_en.add_en = rdy3;
    assign stage_en.cmp_en = rdy4;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) m_tvalid_reg <= v4_reg;
        end
    end

    // Stage one: min and max corners, one bit wider than the center.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            for (int a = 0; a < AXES; a++) begin
                lo_reg[a] <= $signed({s_tdata[a*COORD_WIDTH + COORD_WIDTH-1],
                                      s_tdata[a*COORD_WIDTH +: COORD_WIDTH]})
                           - $signed({2'b00, s_tdata[EXT_LSB + a*EXT_W +: EXT_W]});
                hi_reg[a] <= $signed({s_tdata[a*COORD_WIDTH + COORD_WIDTH-1],
                                      s_tdata[a*COORD_WIDTH +: COORD_WIDTH]})
                           + $signed({2'b00, s_tdata[EXT_LSB + a*EXT_W +: EXT_W]});
            end
        end
    end

    // One evaluator for each plane, all in parallel.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        afc_plane_eval #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_plane_eval (
            .aclk      (aclk),
            .stage_en  (stage_en),
            .plane     (plane_reg[p]),
            .lo_corner (lo_reg),
            .hi_corner (hi_reg),
            .reject_reg(reject[p])
        );
    end

    // Output register: the box is visible when no plane rejects it.
    always_ff @(posedge aclk) begin
        if (rdy5) begin
            visible_reg <= ~|reject;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, visible_reg};

endmodule

// ===== rtl/afc_checker.sv =====
// Port-level checks for the culling block, bound to its top level.
module afc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [afc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import afc_pkg::*;

    localparam int DEPTH = 5;

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    // Count boxes accepted whose result has not yet been taken.
    always_comb begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready) inflight_next = inflight_next + 3'd1;
        if (m_tvalid && m_tready) inflight_next = inflight_next - 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A sink that takes results never blocks the input.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output was ready");

    // No result appears without a box in flight.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result beat without an accepted box");

    // The pipeline never holds more boxes than it has stages.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'(DEPTH))
        else $error("more boxes in flight than pipeline stages");

    // Pad bits of the result beat stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("nonzero pad bits in result beat");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ===== tb/aabb_frustum_cull_test.sv =====
// Self-checking testbench for the axis-aligned box frustum culling block.
`timescale 1ns / 1ps

module aabb_frustum_cull_test;
    import afc_pkg::*;

    localparam int COORD_W      = DEFAULT_COORD_WIDTH;
    localparam int EXT_W        = COORD_W - 1;
    localparam int IN_TDATA_W   = ((6 * COORD_W - 3 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    // Register indexes; the last two lie beyond the plane register map.
    typedef enum logic [CFG_INDEX_W-1:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_TOP    = 3'd2,
        PLANE_BOTTOM = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5,
        SPARE_A      = 3'd6,
        SPARE_B      = 3'd7
    } plane_reg_e;

    // Kinds of random plane sets.
    typedef enum int {
        PLANES_FRUSTUM,
        PLANES_RAW,
        PLANES_EXTREME
    } plane_mix_e;

    // One box beat; centers in the low bits, center_x lowest.
    typedef struct packed {
        logic [AXES-1:0][EXT_W-1:0]   ext;
        logic [AXES-1:0][COORD_W-1:0] ctr;
    } box_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tdata: center_x, center_y, center_z, extent_x, extent_y, extent_z, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tdata: visible, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Local copy of the plane registers and the expected visibility flags.
    logic [CFG_DATA_W-1:0]  plane_copy [REG_COUNT];
    logic                   visible_fifo [$];

    logic idle_on = 1'b1;
    int   long_hold = 0;
    int   stall_left = 0;
    int   error_count = 0;
    int   checked_count = 0;
    int   visible_count = 0;
    int   settings_count = 0;
    int   write_count = 0;
    int   cycle_count = 0;

    aabb_frustum_cull u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stop the run if it goes on far longer than any correct run could.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("aabb_frustum_cull_test failed");
        $finish;
    end

    // Exact p-vertex test of one box against the stored planes.
    function automatic logic box_visible(box_t b);
        longint lo [AXES];
        longint hi [AXES];
        longint c;
        longint e;
        longint n;
        longint sum;
        logic   vis;
        vis = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            c = $signed(b.ctr[a]);
            e = b.ext[a];
            lo[a] = c - e;
            hi[a] = c + e;
        end
        for (int p = 0; p < REG_COUNT && p < DEFAULT_PLANE_COUNT; p++) begin
            sum = $signed(plane_copy[p][D_LSB +: OFFSET_W]);
            sum = sum * (longint'(1) << NORMAL_FRAC);
            for (int a = 0; a < AXES; a++) begin
                n = $signed(plane_copy[p][NX_LSB + NORMAL_W * a +: NORMAL_W]);
                // A zero component counts as non-negative and takes the min corner.
                sum += n * ((n >= 0) ? lo[a] : hi[a]);
            end
            if (sum > 0) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // Predict on every input beat and check every result beat.
    always @(posedge aclk) begin
        logic exp_vis;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                visible_fifo.push_back(box_visible(box_t'(s_tdata[$bits(box_t)-1:0])));
            end
            if (m_tvalid && m_tready) begin
                if (visible_fifo.size() == 0) begin
                    $error("visible: no result expected, actual %0b", m_tdata[0]);
                    error_count++;
                end else begin
                    exp_vis = visible_fifo.pop_front();
                    checked_count++;
                    if (exp_vis) begin
                        visible_count++;
                    end
                    if (m_tdata[0] !== exp_vis) begin
                        $error("visible: expected %0b, actual %0b", exp_vis, m_tdata[0]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, plus a long hold when a test asks for one.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [CFG_DATA_W-1:0] plane_word(int nx, int ny, int nz, int d);
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [15:0] pd;
        px = nx[15:0];
        py = ny[15:0];
        pz = nz[15:0];
        pd = d[15:0];
        return {pd, pz, py, px};
    endfunction

    function automatic box_t make_box(int cx, int cy, int cz, int ex, int ey, int ez);
        box_t b;
        b.ctr[0] = cx[COORD_W-1:0];
        b.ctr[1] = cy[COORD_W-1:0];
        b.ctr[2] = cz[COORD_W-1:0];
        b.ext[0] = ex[EXT_W-1:0];
        b.ext[1] = ey[EXT_W-1:0];
        b.ext[2] = ez[EXT_W-1:0];
        return b;
    endfunction

    // Mostly boxes near the origin, where the frustum planes cut; some fully random.
    function automatic box_t rand_box();
        box_t b;
        int   mode;
        int   cv;
        mode = $urandom_range(0, 2);
        for (int a = 0; a < AXES; a++) begin
            if (mode == 0) begin
                b.ctr[a] = COORD_W'($urandom);
                b.ext[a] = EXT_W'($urandom);
            end else begin
                cv = int'($urandom_range(0, 8191)) - 4096;
                b.ctr[a] = cv[COORD_W-1:0];
                b.ext[a] = EXT_W'($urandom_range(0, 1023));
            end
        end
        return b;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_plane(plane_mix_e kind);
        logic [15:0] corner_vals [4];
        logic [CFG_DATA_W-1:0] w;
        corner_vals[0] = 16'h8000;
        corner_vals[1] = 16'h7FFF;
        corner_vals[2] = 16'h0000;
        corner_vals[3] = 16'hFFFF;
        case (kind)
            PLANES_FRUSTUM: begin
                // Origin inside: offset negative, normals within unit length per axis.
                w = plane_word(int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(0, 32768)) - 16384,
                               -int'($urandom_range(2048, 16384)));
            end
            PLANES_RAW: begin
                w = {$urandom, $urandom};
            end
            default: begin
                for (int k = 0; k < 4; k++) begin
                    w[16 * k +: 16] = corner_vals[$urandom_range(0, 3)];
                end
            end
        endcase
        return w;
    endfunction

    // Offer one box and return in the step in which it is accepted.
    task automatic send_box(input box_t b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - $bits(box_t)){1'b0}}, b};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (visible_fifo.size() != 0);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_plane(input plane_reg_e idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < REG_COUNT && idx < DEFAULT_PLANE_COUNT) begin
            plane_copy[idx] = value;
        end
        write_count++;
        @(posedge aclk);
    endtask

    task automatic load_random_planes(input plane_mix_e kind);
        drain();
        for (int i = 0; i < REG_COUNT; i++) begin
            write_plane(plane_reg_e'(i), rand_plane(kind));
        end
        settings_count++;
    endtask

    // All planes zero after reset: nothing is rejected, whatever the box.
    task automatic test_reset_planes();
        settings_count++;
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-1, -1, -1, 1, 1, 1));
    endtask

    // Hand-picked planes: touching, just outside, negative and zero components, extremes.
    task automatic test_directed_planes();
        drain();
        write_plane(PLANE_LEFT, plane_word(16384, 0, 0, 0));
        settings_count++;
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(1, 0, 0, 0, 0, 0));
        send_box(make_box(16, 5, -5, 16, 7, 7));
        send_box(make_box(17, 0, 0, 16, 0, 0));
        drain();
        write_plane(PLANE_RIGHT, plane_word(-16384, 0, 0, -16384));
        write_plane(PLANE_TOP, plane_word(0, 16384, 0, -1600));
        write_plane(PLANE_BOTTOM, plane_word(32767, 32767, 32767, -32768));
        write_plane(PLANE_NEAR, plane_word(0, 0, -16384, -8000));
        settings_count++;
        send_box(make_box(-32768, 0, 0, 0, 0, 0));
        send_box(make_box(-16384, 0, 0, 0, 0, 0));
        send_box(make_box(-100, 1600, 0, 0, 0, 0));
        send_box(make_box(-100, 1601, 0, 0, 0, 0));
        send_box(make_box(-20000, -20000, -20000, 32767, 32767, 32767));
        drain();
        write_plane(PLANE_FAR, plane_word(0, 0, 0, 32767));
        settings_count++;
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-32768, -32768, 32767, 32767, 32767, 32767));
        drain();
        write_plane(PLANE_FAR, plane_word(-32768, -32768, -32768, -32768));
        settings_count++;
        send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
        send_box(make_box(-100, 0, 0, 0, 0, 0));
    endtask

    // Writes to indexes beyond the map must leave the planes alone.
    task automatic test_spare_index();
        drain();
        for (int i = 0; i < REG_COUNT; i++) begin
            write_plane(plane_reg_e'(i), '0);
        end
        write_plane(SPARE_A, plane_word(0, 0, 0, 32767));
        write_plane(SPARE_B, plane_word(16384, 16384, 16384, 32767));
        settings_count++;
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(-32768, 100, -100, 0, 32767, 1));
    endtask

    task automatic test_random_planes();
        plane_mix_e mixes [5];
        int         counts [5];
        mixes  = '{PLANES_FRUSTUM, PLANES_RAW, PLANES_EXTREME, PLANES_FRUSTUM, PLANES_RAW};
        counts = '{250, 200, 150, 250, 150};
        for (int ph = 0; ph < 5; ph++) begin
            load_random_planes(mixes[ph]);
            repeat (counts[ph]) send_box(rand_box());
        end
    endtask

    // Hold the result side for a long stretch so the pipeline fills and stalls input.
    task automatic test_backpressure();
        load_random_planes(PLANES_FRUSTUM);
        long_hold = 300;
        repeat (80) send_box(rand_box());
    endtask

    // Sender stops mid-stream until every result is back, then carries on.
    task automatic test_sender_pause();
        load_random_planes(PLANES_RAW);
        repeat (40) send_box(rand_box());
        drain();
        repeat (40) send_box(rand_box());
    endtask

    // Back-to-back beats with both sides always ready.
    task automatic test_full_rate();
        idle_on = 1'b0;
        load_random_planes(PLANES_FRUSTUM);
        repeat (200) send_box(rand_box());
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= PLANE_LEFT;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        for (int i = 0; i < REG_COUNT; i++) begin
            plane_copy[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_planes();
        test_directed_planes();
        test_spare_index();
        test_random_planes();
        test_backpressure();
        test_sender_pause();
        test_full_rate();

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d boxes (%0d visible, %0d culled) over %0d plane settings.",
                 checked_count, visible_count, checked_count - visible_count,
                 settings_count);
        $display("Included %0d register writes, out-of-map indexes, a long output stall "
                 , write_count, "and a full-rate stretch.");
        if (error_count == 0) begin
            $display("aabb_frustum_cull_test passed");
        end else begin
            $display("aabb_frustum_cull_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/afc_pkg.sv
rtl/afc_plane_eval.sv
rtl/aabb_frustum_cull.sv
rtl/afc_checker.sv
tb/aabb_frustum_cull_test.sv
